// File: rtl/mftc_pkg.sv
// shared types and constants for the masked flow trace counter table
// used by mftc_match, the top unit and the testbench; depends on nothing
package mftc_pkg;

	localparam int FILTERS  = 16;
	localparam int STATUSES = 26;

	localparam int SLOT_W   = (FILTERS > 1) ? $clog2(FILTERS) : 1;
	localparam int COUNT_W  = $clog2(FILTERS + 1);
	localparam int CTR_N    = FILTERS * STATUSES;
	localparam int CADDR_W  = (CTR_N > 1) ? $clog2(CTR_N) : 1;
	localparam int ZERO_W   = (STATUSES > 1) ? $clog2(STATUSES) : 1;
	localparam int STATUS_W = 5;
	localparam int MASK_W   = 10;

	typedef enum logic [1:0] {
		OP_TRACE = 2'd0,
		OP_ADD   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	localparam logic [1:0] RES_DONE     = 2'd0;
	localparam logic [1:0] RES_EXISTS   = 2'd1;
	localparam logic [1:0] RES_FULL     = 2'd2;
	localparam logic [1:0] RES_NO_INDEX = 2'd3;

	typedef struct packed {
		op_t                 op;
		logic [STATUS_W-1:0] status;
		logic [7:0]          proto;
		logic [63:0]         src_ip_hi;
		logic [63:0]         src_ip_lo;
		logic [63:0]         dst_ip_hi;
		logic [63:0]         dst_ip_lo;
		logic [15:0]         src_port;
		logic [15:0]         dst_port;
		logic [3:0]          filter_index;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  result_code;
		logic [4:0]  filters_in_use;
		logic [4:0]  matched_filters;
		logic [63:0] counter_value;
		logic [7:0]  rd_proto;
		logic [63:0] rd_src_ip_hi;
		logic [63:0] rd_src_ip_lo;
		logic [63:0] rd_dst_ip_hi;
		logic [63:0] rd_dst_ip_lo;
		logic [15:0] rd_src_port;
		logic [15:0] rd_dst_port;
	} rsp_t;

	// one filter slot as held in the key memory
	typedef struct packed {
		logic [7:0]        proto;
		logic [63:0]       src_hi;
		logic [63:0]       src_lo;
		logic [63:0]       dst_hi;
		logic [63:0]       dst_lo;
		logic [15:0]       src_port;
		logic [15:0]       dst_port;
		logic [MASK_W-1:0] mask;
	} key_entry_t;

	// counters of a slot are contiguous: slot * STATUSES + status
	function automatic logic [CADDR_W-1:0] ctr_addr(input logic [SLOT_W-1:0] slot,
			input logic [STATUS_W-1:0] st);
		return CADDR_W'(int'(slot) * STATUSES + int'(st));
	endfunction

endpackage

// File: rtl/mftc_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no package dependency
module mftc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

// File: rtl/mftc_match.sv
// masked tuple compare stage: key memory output against the held request
// depends on mftc_pkg
module mftc_match (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vld_s1,
	input  logic [mftc_pkg::SLOT_W-1:0] slot_s1,
	input  mftc_pkg::key_entry_t        entry_s1,
	input  mftc_pkg::cmd_t              query,
	output logic                        vld_s2,
	output logic                        hit_s2,
	output logic [mftc_pkg::SLOT_W-1:0] slot_s2
);
	import mftc_pkg::*;

	logic [MASK_W-1:0] m;
	logic              hit;

	assign m = entry_s1.mask;

	// protocol always compared, zero words and ports of the key are wildcards
	always_comb begin
		hit = (query.proto == entry_s1.proto)
			&& ((query.src_ip_hi & {{32{m[0]}}, {32{m[1]}}}) == entry_s1.src_hi)
			&& ((query.src_ip_lo & {{32{m[2]}}, {32{m[3]}}}) == entry_s1.src_lo)
			&& ((query.dst_ip_hi & {{32{m[4]}}, {32{m[5]}}}) == entry_s1.dst_hi)
			&& ((query.dst_ip_lo & {{32{m[6]}}, {32{m[7]}}}) == entry_s1.dst_lo)
			&& ((query.src_port & {16{m[8]}}) == entry_s1.src_port)
			&& ((query.dst_port & {16{m[9]}}) == entry_s1.dst_port);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		hit_s2  <= hit;
		slot_s2 <= slot_s1;
	end

endmodule

// File: rtl/masked_flow_trace_counter_table_unit.sv
// masked five-tuple filter table with per-filter 64-bit event counters
// depends on mftc_pkg, mftc_ram, mftc_match
//
// usage: drive cmd and raise start; the command transfers at a clock edge
// with start high and busy low. exactly one result per command appears on
// rsp for one cycle with done high; the receiver cannot stall, so it must
// take every result in that cycle.
// the clear, a full add, a trace with bad status or empty table and a bad
// read give their result straight from idle; a read goes through the key
// and counter memory read; a trace scans the held filters, as does an add
// unless the table is empty, and an add that finds no duplicate then writes
// the new slot. the filter scan reads one slot a cycle from the key memory;
// the counter memory is read-modify-written for each hit behind the scan,
// after the key read and the compare stage, and an add zeroes the new
// slot's counters one per cycle.
// busy stays high until the result is presented, so one command is at work
// at a time. reset empties the table; no clearing pass is needed because
// only slots below the fill count are ever read.
module masked_flow_trace_counter_table_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  mftc_pkg::cmd_t cmd,
	output logic           done,
	output mftc_pkg::rsp_t rsp
);
	import mftc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_ZERO,
		ST_RD_ISSUE,
		ST_RD_WAIT
	} state_t;

	state_t             state_q;
	cmd_t               req_q;
	rsp_t               rsp_q;
	logic               done_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] matched_q;
	logic               dup_q;
	logic [SLOT_W-1:0]  scan_q;
	logic [ZERO_W-1:0]  zero_q;
	logic               v1_q;
	logic               v3_q;
	logic [SLOT_W-1:0]  slot_s1;
	logic [CADDR_W-1:0] caddr_s3;

	logic               v2;
	logic               hit_s2;
	logic [SLOT_W-1:0]  slot_s2;

	key_entry_t         key_rdata;
	key_entry_t         key_wdata;
	logic               key_we;
	logic [SLOT_W-1:0]  key_raddr;
	logic [SLOT_W-1:0]  key_waddr;

	logic [63:0]        ctr_rdata;
	logic [63:0]        ctr_wdata;
	logic               ctr_we;
	logic [CADDR_W-1:0] ctr_raddr;
	logic [CADDR_W-1:0] ctr_waddr;

	logic               cmd_bad_status;
	logic               cmd_bad_index;
	logic               hit_fire;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	assign cmd_bad_status = int'(cmd.status) >= STATUSES;
	assign cmd_bad_index  = (int'(cmd.filter_index) >= int'(count_q))
		|| (int'(cmd.filter_index) >= FILTERS);
	assign hit_fire = v2 && hit_s2;

	// new entry with its derived mask
	always_comb begin
		key_wdata          = '0;
		key_wdata.proto    = req_q.proto;
		key_wdata.src_hi   = req_q.src_ip_hi;
		key_wdata.src_lo   = req_q.src_ip_lo;
		key_wdata.dst_hi   = req_q.dst_ip_hi;
		key_wdata.dst_lo   = req_q.dst_ip_lo;
		key_wdata.src_port = req_q.src_port;
		key_wdata.dst_port = req_q.dst_port;
		key_wdata.mask     = {|req_q.dst_port, |req_q.src_port,
			|req_q.dst_ip_lo[31:0], |req_q.dst_ip_lo[63:32],
			|req_q.dst_ip_hi[31:0], |req_q.dst_ip_hi[63:32],
			|req_q.src_ip_lo[31:0], |req_q.src_ip_lo[63:32],
			|req_q.src_ip_hi[31:0], |req_q.src_ip_hi[63:32]};
	end

	assign key_we    = (state_q == ST_ZERO) && (zero_q == '0);
	assign key_waddr = SLOT_W'(count_q);
	assign key_raddr = (state_q == ST_SCAN) ? scan_q : SLOT_W'(req_q.filter_index);

	assign ctr_raddr = (state_q == ST_RD_ISSUE)
		? ctr_addr(SLOT_W'(req_q.filter_index), req_q.status)
		: ctr_addr(slot_s2, req_q.status);
	assign ctr_we    = (state_q == ST_ZERO) || v3_q;
	assign ctr_waddr = (state_q == ST_ZERO)
		? ctr_addr(SLOT_W'(count_q), STATUS_W'(zero_q)) : caddr_s3;
	assign ctr_wdata = (state_q == ST_ZERO) ? 64'd0 : ctr_rdata + 64'd1;

	mftc_ram #(
		.WIDTH($bits(key_entry_t)),
		.DEPTH(FILTERS)
	) u_key_ram (
		.clk     (clk),
		.we      (key_we),
		.waddr   (key_waddr),
		.wdata   (key_wdata),
		.raddr   (key_raddr),
		.rdata_q (key_rdata)
	);

	mftc_ram #(
		.WIDTH(64),
		.DEPTH(CTR_N)
	) u_ctr_ram (
		.clk     (clk),
		.we      (ctr_we),
		.waddr   (ctr_waddr),
		.wdata   (ctr_wdata),
		.raddr   (ctr_raddr),
		.rdata_q (ctr_rdata)
	);

	mftc_match u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_s1   (v1_q),
		.slot_s1  (slot_s1),
		.entry_s1 (key_rdata),
		.query    (req_q),
		.vld_s2   (v2),
		.hit_s2   (hit_s2),
		.slot_s2  (slot_s2)
	);

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= cmd;
		end
		slot_s1  <= scan_q;
		caddr_s3 <= ctr_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rsp_q     <= '0;
			done_q    <= 1'b0;
			count_q   <= '0;
			matched_q <= '0;
			dup_q     <= 1'b0;
			scan_q    <= '0;
			zero_q    <= '0;
			v1_q      <= 1'b0;
			v3_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v1_q   <= (state_q == ST_SCAN);
			v3_q   <= hit_fire && (req_q.op == OP_TRACE);
			if (hit_fire) begin
				matched_q <= matched_q + COUNT_W'(1);
				dup_q     <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						matched_q <= '0;
						dup_q     <= 1'b0;
						scan_q    <= '0;
						zero_q    <= '0;
						rsp_q     <= '0;
						rsp_q.filters_in_use <= 5'(count_q);
						case (cmd.op)
							OP_TRACE: begin
								if (cmd_bad_status || count_q == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							OP_ADD: begin
								if (int'(count_q) >= FILTERS) begin
									done_q            <= 1'b1;
									rsp_q.result_code <= RES_FULL;
								end else if (count_q == '0) begin
									state_q <= ST_ZERO;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							OP_CLEAR: begin
								count_q              <= '0;
								done_q               <= 1'b1;
								rsp_q.filters_in_use <= '0;
							end
							OP_READ: begin
								if (cmd_bad_status || cmd_bad_index) begin
									done_q            <= 1'b1;
									rsp_q.result_code <= RES_NO_INDEX;
								end else begin
									state_q <= ST_RD_ISSUE;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + SLOT_W'(1);
					if (COUNT_W'(scan_q) + COUNT_W'(1) == count_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// wait until the last compare and counter write are through
					if (!v1_q && !v2 && !v3_q) begin
						if (req_q.op == OP_TRACE) begin
							state_q               <= ST_IDLE;
							done_q                <= 1'b1;
							rsp_q.matched_filters <= 5'(matched_q);
						end else if (dup_q) begin
							state_q           <= ST_IDLE;
							done_q            <= 1'b1;
							rsp_q.result_code <= RES_EXISTS;
						end else begin
							state_q <= ST_ZERO;
							zero_q  <= '0;
						end
					end
				end
				ST_ZERO: begin
					zero_q <= zero_q + ZERO_W'(1);
					if (zero_q == ZERO_W'(STATUSES - 1)) begin
						count_q              <= count_q + COUNT_W'(1);
						state_q              <= ST_IDLE;
						done_q               <= 1'b1;
						rsp_q.result_code    <= RES_DONE;
						rsp_q.filters_in_use <= 5'(count_q + COUNT_W'(1));
					end
				end
				ST_RD_ISSUE: begin
					state_q <= ST_RD_WAIT;
				end
				ST_RD_WAIT: begin
					state_q            <= ST_IDLE;
					done_q             <= 1'b1;
					rsp_q.counter_value <= ctr_rdata;
					rsp_q.rd_proto     <= key_rdata.proto;
					rsp_q.rd_src_ip_hi <= key_rdata.src_hi;
					rsp_q.rd_src_ip_lo <= key_rdata.src_lo;
					rsp_q.rd_dst_ip_hi <= key_rdata.dst_hi;
					rsp_q.rd_dst_ip_lo <= key_rdata.dst_lo;
					rsp_q.rd_src_port  <= key_rdata.src_port;
					rsp_q.rd_dst_port  <= key_rdata.dst_port;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a result is only presented once the command has fully retired
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result presented while busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= FILTERS)
		else $error("fill count above table size");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(v1_q || v2 || v3_q))
		else $error("scan pipeline active while idle");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.result_code == RES_FULL) |-> (int'(rsp.filters_in_use) == FILTERS))
		else $error("table full reported below capacity");

	a_ctr_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		(ctr_we && state_q != ST_ZERO) |-> (req_q.op == OP_TRACE && $past(hit_fire)))
		else $error("counter increment without a trace hit");

endmodule

// File: test/tb_top.sv
// self-checking testbench for masked_flow_trace_counter_table_unit
// uses mftc_pkg for the command and response types; models the filter table in place
`timescale 1ns / 100ps

module tb_top;
	import mftc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 60;
	localparam int ITEM_TARGET    = 600;

	typedef struct {
		cmd_t c;
		bit   drain;
	} pend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	cmd_t cmd = '0;
	rsp_t rsp;

	masked_flow_trace_counter_table_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// filter table as the block should hold it
	cmd_t        flt_key [FILTERS];
	logic [9:0]  flt_mask [FILTERS];
	logic [63:0] flt_ctr [FILTERS][STATUSES];
	int          flt_fill = 0;

	pend_t cmd_backlog[$];
	rsp_t  rsp_expected[$];
	cmd_t  known[$];
	bit    drain_next = 1'b0;
	pend_t drv_next;

	int n_sent = 0;
	int n_got = 0;
	int err_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int quiet = 0;
	int n_full = 0;
	int n_dup = 0;
	int n_noidx = 0;
	int n_incr = 0;

	function automatic bit slot_hit(int s, cmd_t c);
		logic [9:0] m;
		m = flt_mask[s];
		return c.proto == flt_key[s].proto
			&& (c.src_ip_hi & {{32{m[0]}}, {32{m[1]}}}) == flt_key[s].src_ip_hi
			&& (c.src_ip_lo & {{32{m[2]}}, {32{m[3]}}}) == flt_key[s].src_ip_lo
			&& (c.dst_ip_hi & {{32{m[4]}}, {32{m[5]}}}) == flt_key[s].dst_ip_hi
			&& (c.dst_ip_lo & {{32{m[6]}}, {32{m[7]}}}) == flt_key[s].dst_ip_lo
			&& (c.src_port & {16{m[8]}}) == flt_key[s].src_port
			&& (c.dst_port & {16{m[9]}}) == flt_key[s].dst_port;
	endfunction

	// applies one command to the table and returns the response it must give
	function automatic rsp_t table_response(cmd_t c);
		rsp_t r;
		int s;
		int st;
		int hits;
		bit dup;
		logic [9:0] m;
		r = '0;
		hits = 0;
		dup = 1'b0;
		case (c.op)
			OP_TRACE: begin
				if (c.status < STATUSES) begin
					for (s = 0; s < flt_fill; s++) begin
						if (slot_hit(s, c)) begin
							flt_ctr[s][c.status] = flt_ctr[s][c.status] + 64'd1;
							hits++;
						end
					end
				end
			end
			OP_ADD: begin
				if (flt_fill >= FILTERS) begin
					r.result_code = RES_FULL;
				end else begin
					for (s = 0; s < flt_fill && !dup; s++)
						dup = slot_hit(s, c);
					if (dup) begin
						r.result_code = RES_EXISTS;
					end else begin
						m = {|c.dst_port, |c.src_port,
							|c.dst_ip_lo[31:0], |c.dst_ip_lo[63:32],
							|c.dst_ip_hi[31:0], |c.dst_ip_hi[63:32],
							|c.src_ip_lo[31:0], |c.src_ip_lo[63:32],
							|c.src_ip_hi[31:0], |c.src_ip_hi[63:32]};
						flt_key[flt_fill] = c;
						flt_mask[flt_fill] = m;
						for (st = 0; st < STATUSES; st++)
							flt_ctr[flt_fill][st] = '0;
						flt_fill++;
					end
				end
			end
			OP_CLEAR: begin
				for (s = 0; s < FILTERS; s++)
					for (st = 0; st < STATUSES; st++)
						flt_ctr[s][st] = '0;
				flt_fill = 0;
			end
			default: begin
				if (c.filter_index >= flt_fill || c.status >= STATUSES) begin
					r.result_code = RES_NO_INDEX;
				end else begin
					r.counter_value = flt_ctr[c.filter_index][c.status];
					r.rd_proto = flt_key[c.filter_index].proto;
					r.rd_src_ip_hi = flt_key[c.filter_index].src_ip_hi;
					r.rd_src_ip_lo = flt_key[c.filter_index].src_ip_lo;
					r.rd_dst_ip_hi = flt_key[c.filter_index].dst_ip_hi;
					r.rd_dst_ip_lo = flt_key[c.filter_index].dst_ip_lo;
					r.rd_src_port = flt_key[c.filter_index].src_port;
					r.rd_dst_port = flt_key[c.filter_index].dst_port;
				end
			end
		endcase
		r.filters_in_use = 5'(flt_fill);
		r.matched_filters = 5'(hits);
		return r;
	endfunction

	task automatic flag_error(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic cmp_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			flag_error($sformatf("%s got %h expected %h", name, got, want));
	endtask

	// random tuple; each address word and port is zero with the given chance
	function automatic cmd_t rand_tuple(int zero_pct);
		cmd_t c;
		logic [255:0] a;
		int w;
		c = '0;
		c.op = OP_ADD;
		for (w = 0; w < 8; w++) begin
			if ($urandom_range(0, 99) < zero_pct)
				a[w*32 +: 32] = '0;
			else if ($urandom_range(0, 7) == 0)
				a[w*32 +: 32] = '1;
			else
				a[w*32 +: 32] = $urandom;
		end
		{c.src_ip_hi, c.src_ip_lo, c.dst_ip_hi, c.dst_ip_lo} = a;
		c.src_port = ($urandom_range(0, 99) < zero_pct) ? 16'h0 : 16'($urandom);
		c.dst_port = ($urandom_range(0, 99) < zero_pct) ? 16'h0 : 16'($urandom);
		case ($urandom_range(0, 3))
			0: c.proto = 8'h06;
			1: c.proto = 8'h11;
			default: c.proto = 8'($urandom);
		endcase
		c.status = 5'($urandom);
		c.filter_index = 4'($urandom);
		return c;
	endfunction

	// trace event aimed at a filter key: wildcard words get random content
	function automatic cmd_t event_for(cmd_t k);
		cmd_t e;
		logic [255:0] a;
		int w;
		e = k;
		e.op = OP_TRACE;
		a = {k.src_ip_hi, k.src_ip_lo, k.dst_ip_hi, k.dst_ip_lo};
		for (w = 0; w < 8; w++)
			if (a[w*32 +: 32] == 0)
				a[w*32 +: 32] = $urandom;
		if ($urandom_range(0, 5) == 0) begin
			w = $urandom_range(0, 255);
			a[w] = ~a[w];
		end
		{e.src_ip_hi, e.src_ip_lo, e.dst_ip_hi, e.dst_ip_lo} = a;
		if (k.src_port == 0)
			e.src_port = 16'($urandom);
		if (k.dst_port == 0)
			e.dst_port = 16'($urandom);
		if ($urandom_range(0, 15) == 0)
			e.proto = e.proto ^ 8'h01;
		if ($urandom_range(0, 9) == 0)
			e.status = 5'($urandom_range(STATUSES, 31));
		else
			e.status = 5'($urandom_range(0, STATUSES - 1));
		e.filter_index = 4'($urandom);
		return e;
	endfunction

	task automatic push_cmd(cmd_t c);
		pend_t p;
		p.c = c;
		p.drain = drain_next;
		cmd_backlog.push_back(p);
		drain_next = 1'b0;
	endtask

	// driver: bursts of transfers with random gaps in between
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				rsp_expected.push_back(table_response(cmd));
				n_sent++;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (cmd_backlog.size() == 0 ||
						(cmd_backlog[0].drain && n_got != n_sent)) begin
					start <= 1'b0;
				end else begin
					drv_next = cmd_backlog.pop_front();
					cmd <= drv_next.c;
					start <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 15);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
					end
				end
			end
		end
	end

	// monitor: every strobed response is checked against the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (rsp_expected.size() == 0) begin
				flag_error("response with no transfer outstanding");
			end else begin
				want = rsp_expected.pop_front();
				cmp_field("result_code", 64'(rsp.result_code), 64'(want.result_code));
				cmp_field("filters_in_use", 64'(rsp.filters_in_use),
					64'(want.filters_in_use));
				cmp_field("matched_filters", 64'(rsp.matched_filters),
					64'(want.matched_filters));
				cmp_field("counter_value", rsp.counter_value, want.counter_value);
				cmp_field("rd_proto", 64'(rsp.rd_proto), 64'(want.rd_proto));
				cmp_field("rd_src_ip_hi", rsp.rd_src_ip_hi, want.rd_src_ip_hi);
				cmp_field("rd_src_ip_lo", rsp.rd_src_ip_lo, want.rd_src_ip_lo);
				cmp_field("rd_dst_ip_hi", rsp.rd_dst_ip_hi, want.rd_dst_ip_hi);
				cmp_field("rd_dst_ip_lo", rsp.rd_dst_ip_lo, want.rd_dst_ip_lo);
				cmp_field("rd_src_port", 64'(rsp.rd_src_port), 64'(want.rd_src_port));
				cmp_field("rd_dst_port", 64'(rsp.rd_dst_port), 64'(want.rd_dst_port));
				if (want.result_code == RES_FULL)
					n_full++;
				if (want.result_code == RES_EXISTS)
					n_dup++;
				if (want.result_code == RES_NO_INDEX)
					n_noidx++;
				n_incr += int'(want.matched_filters);
			end
			n_got <= n_got + 1;
		end
	end

	// watchdog on cycles with neither a command nor a response transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet <= 0;
			end else if (quiet >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	initial begin
		cmd_t c;
		int i;
		int pick;
		int phase;
		int lim;
		bit fill;

		// directed: empty table, wildcard and exact filters, duplicates, status limits
		c = '0; c.op = OP_READ;
		push_cmd(c);
		c = rand_tuple(0); c.op = OP_TRACE; c.proto = 8'h06;
		push_cmd(c);
		c = '0; c.op = OP_ADD; c.proto = 8'h06;
		push_cmd(c);
		c = '1; c.op = OP_ADD;
		push_cmd(c);
		push_cmd(c);
		c = rand_tuple(0); c.op = OP_ADD; c.proto = 8'h06;
		push_cmd(c);
		c = '0; c.op = OP_ADD; c.proto = 8'h11;
		c.src_ip_hi[63:32] = 32'hDEAD_0001; c.dst_ip_lo[63:32] = 32'h8000_0000;
		c.dst_port = 16'h0050;
		push_cmd(c);
		c = '1; c.op = OP_TRACE; c.status = 5'd25; c.filter_index = '0;
		push_cmd(c);
		c = rand_tuple(20); c.op = OP_TRACE; c.proto = 8'h06; c.status = '0;
		push_cmd(c);
		c.status = 5'd31;
		push_cmd(c);
		c = rand_tuple(0); c.op = OP_TRACE; c.proto = 8'h11;
		c.src_ip_hi[63:32] = 32'hDEAD_0001; c.dst_ip_lo[63:32] = 32'h8000_0000;
		c.dst_port = 16'h0050; c.status = 5'd13;
		push_cmd(c);
		c = '0; c.op = OP_READ; c.filter_index = 4'd1; c.status = 5'd25;
		push_cmd(c);
		c.filter_index = 4'd0; c.status = 5'd0;
		push_cmd(c);
		c.filter_index = 4'd2; c.status = 5'd13;
		push_cmd(c);
		c.filter_index = 4'd0; c.status = 5'd26;
		push_cmd(c);
		c.filter_index = 4'd15; c.status = 5'd0;
		push_cmd(c);
		c.filter_index = 4'd3;
		push_cmd(c);
		c = '1; c.op = OP_CLEAR;
		drain_next = 1'b1;
		push_cmd(c);
		c = '0; c.op = OP_READ;
		push_cmd(c);
		c = '1; c.op = OP_TRACE;
		push_cmd(c);

		// random phases; even ones fill the table past full first
		phase = 0;
		while (cmd_backlog.size() < ITEM_TARGET) begin
			fill = (phase % 2 == 0);
			drain_next = 1'b1;
			if (phase % 3 != 2) begin
				c = rand_tuple(0);
				c.op = OP_CLEAR;
				push_cmd(c);
				known.delete();
			end
			for (i = 0; i < 40 && cmd_backlog.size() < ITEM_TARGET; i++) begin
				pick = $urandom_range(0, 99);
				if (fill && i < 18) begin
					c = rand_tuple(3);
					known.push_back(c);
				end else if (pick < 25) begin
					if (known.size() != 0 && $urandom_range(0, 3) == 0)
						c = event_for(known[$urandom_range(0, known.size() - 1)]);
					else
						c = rand_tuple(30);
					c.op = OP_ADD;
					known.push_back(c);
				end else if (pick < 70) begin
					if (known.size() != 0 && $urandom_range(0, 3) != 0) begin
						c = event_for(known[$urandom_range(0, known.size() - 1)]);
					end else begin
						c = rand_tuple(30);
						c.op = OP_TRACE;
					end
				end else if (pick < 92) begin
					c = rand_tuple(50);
					c.op = OP_READ;
					lim = (known.size() > FILTERS) ? FILTERS - 1 : known.size() - 1;
					if (lim >= 0 && $urandom_range(0, 3) != 0)
						c.filter_index = 4'($urandom_range(0, lim));
					if ($urandom_range(0, 7) != 0)
						c.status = 5'($urandom_range(0, STATUSES - 1));
				end else begin
					// noise: every field random, any op
					c = rand_tuple(0);
					c.op = op_t'($urandom_range(0, 3));
					if (c.op == OP_CLEAR)
						known.delete();
				end
				push_cmd(c);
			end
			phase++;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || start || n_got != n_sent)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (rsp_expected.size() != 0)
			flag_error($sformatf("%0d responses never arrived", rsp_expected.size()));

		$display("covered %0d commands in %0d phases: %0d table full, %0d duplicate adds,",
			n_sent, phase, n_full, n_dup);
		$display("%0d rejected reads, %0d counter increments", n_noidx, n_incr);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
